// ----- hdl/fcsp_pkg.sv -----
// shared types, widths and codes for the frame cache slot policy block
// no dependencies; imported by fcsp_alu and frame_cache_slot_policy
`default_nettype none

package fcsp_pkg;

	localparam int FRAME_W     = 32;
	localparam int KIND_W      = 3;
	localparam int SEL_W       = 4;
	localparam int RTYPE_W     = 2;
	localparam int SLOTS_DEF   = 4;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 80;

	// event kinds carried on tuser
	localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PREV    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_JUMP    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REFRESH = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

	// remote request types
	localparam logic [RTYPE_W-1:0] REQ_PREV = 2'd0;
	localparam logic [RTYPE_W-1:0] REQ_NEXT = 2'd1;
	localparam logic [RTYPE_W-1:0] REQ_CUR  = 2'd2;

	// operand set for the shared add / compare unit
	typedef struct packed {
		logic [FRAME_W-1:0] op_a;
		logic [FRAME_W-1:0] op_b;
		logic               sub;
		logic [FRAME_W-1:0] eq_a;
		logic [FRAME_W-1:0] eq_b;
	} alu_in_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/fcsp_alu.sv -----
// shared add/subtract and equality unit used by the slot walk
// depends on fcsp_pkg for widths and the operand struct
`default_nettype none

module fcsp_alu
	import fcsp_pkg::*;
(
	input  alu_in_t            op,
	output logic [FRAME_W-1:0] sum,
	output logic               eq
);

	// a + b or a - b, wrapping at the frame id width
	assign sum = op.op_a + (op.op_b ^ {FRAME_W{op.sub}}) + FRAME_W'(op.sub);
	assign eq  = (op.eq_a == op.eq_b);

endmodule

`default_nettype wire

// ----- hdl/frame_cache_slot_policy.sv -----
// top level of the frame cache slot policy block: sequencer, slot table, result register
// depends on fcsp_pkg and fcsp_alu
`default_nettype none

// Keeps a table of SLOTS cached frame ids with occupied and latest marks, a selected
// slot and a follow-newest flag. Each request on the slave stream is one event (kind on
// tuser) and yields exactly one result on the master stream. Commit, previous, next and
// jump latest walk the table one slot per cycle through a single shared adder and
// comparator: the accepting cycle is followed by a set-up step, the walk over all SLOTS
// slots and a finish step that updates the table and loads the result register; the
// finish step waits while the result register is still full and not being taken.
// Refresh, clear and the unused kinds skip the walk. s_tready is high
// only while the sequencer is idle; a finished result sits in its own register, so the
// next request is taken even while the previous result still waits for m_tready.
// Frame ids are compared as serial numbers that wrap at 2^32. No clearing pass is
// needed after reset: ids of slots that are not occupied never decide a result.

module frame_cache_slot_policy
	import fcsp_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// frame_id[31:0], reset_cache[32], mark_latest[33], present_now[34],
	// clean_refresh[35], zero pad[39:36]
	input  wire  [S_TDATA_W-1:0]   s_tdata,
	// kind[2:0]
	input  wire  [KIND_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// selection_valid[0], selected_index[4:1], selected_frame[36:5], presented[37],
	// written_slot[41:38], request_valid[42], request_type[44:43],
	// request_anchor[76:45], clean_redraw[77], selection_changed[78], zero pad[79]
	output logic [M_TDATA_W-1:0]   m_tdata
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// sequencer and request capture
	state_t              state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [FRAME_W-1:0]  fid_q;
	logic                latest_q;
	logic                pres_q;
	logic                clean_req_q;

	// slot table: ids are payload, marks are control
	logic [FRAME_W-1:0]  id_mem [SLOTS];
	logic [SLOTS-1:0]    occ_q;
	logic [SLOTS-1:0]    lat_q;

	// selection state; sel_frame_q mirrors the id of the selected slot
	logic                has_sel_q;
	logic [IDX_W-1:0]    sel_q;
	logic [FRAME_W-1:0]  sel_frame_q;
	logic                follow_q;
	logic                clean_pend_q;

	// walk state
	logic [IDX_W-1:0]    scan_q;
	logic [FRAME_W-1:0]  target_q;
	logic                newer_q;
	logic                match_v_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                free_v_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                cand_v_q;
	logic [IDX_W-1:0]    cand_idx_q;
	logic [FRAME_W-1:0]  cand_id_q;
	logic                lat_v_q;
	logic [IDX_W-1:0]    lat_idx_q;
	logic [FRAME_W-1:0]  lat_id_q;

	// result register
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic                in_acc;
	logic                fin_go;
	logic                clr_now;
	logic                back;
	logic                needs_walk;
	logic [FRAME_W-1:0]  sel_frame_cur;
	logic [FRAME_W-1:0]  scan_id;
	logic                scan_occ;
	logic                scan_lat;
	logic                scan_excl;

	alu_in_t             alu_op;
	logic [FRAME_W-1:0]  alu_sum;
	logic                alu_eq;

	// finish-step next values and result fields
	logic [IDX_W-1:0]    slot_pick;
	logic                n_has_sel;
	logic [IDX_W-1:0]    n_sel;
	logic [FRAME_W-1:0]  n_sel_frame;
	logic                n_follow;
	logic                n_clean;
	logic                wr_en;
	logic [SLOTS-1:0]    n_lat;
	logic                r_presented;
	logic [SEL_W-1:0]    r_written;
	logic                r_req;
	logic [RTYPE_W-1:0]  r_rtype;
	logic [FRAME_W-1:0]  r_anchor;
	logic                r_redraw;
	logic                r_changed;
	logic [SEL_W-1:0]    r_index;
	logic [FRAME_W-1:0]  r_frame;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// finishing waits until the result register is free
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// clear and commit-with-reset empty the table as the request is taken
	assign clr_now = in_acc && ((s_tuser == KIND_CLEAR) ||
	                            ((s_tuser == KIND_COMMIT) && s_tdata[32]));

	assign back       = (kind_q == KIND_PREV);
	assign needs_walk = (kind_q == KIND_COMMIT) || (kind_q == KIND_PREV) ||
	                    (kind_q == KIND_NEXT) || (kind_q == KIND_JUMP);

	assign sel_frame_cur = has_sel_q ? sel_frame_q : '0;

	assign scan_id   = id_mem[scan_q];
	assign scan_occ  = occ_q[scan_q];
	assign scan_lat  = lat_q[scan_q];
	assign scan_excl = has_sel_q && (scan_q == sel_q);

	// shared unit operands: set-up works out the neighbour id or the newer flag,
	// the walk orders each slot against the running eviction candidate
	always_comb begin
		alu_op.op_a = scan_id;
		alu_op.op_b = cand_id_q;
		alu_op.sub  = 1'b1;
		alu_op.eq_a = scan_id;
		alu_op.eq_b = target_q;
		if (state_q == ST_PREP) begin
			if (kind_q == KIND_COMMIT) begin
				alu_op.op_a = sel_frame_q;
				alu_op.op_b = fid_q;
				alu_op.sub  = 1'b1;
			end else begin
				alu_op.op_a = sel_frame_cur;
				alu_op.op_b = FRAME_W'(1);
				alu_op.sub  = back;
			end
		end else if (!newer_q) begin
			alu_op.op_a = cand_id_q;
			alu_op.op_b = scan_id;
		end
	end

	fcsp_alu u_alu (
		.op  (alu_op),
		.sum (alu_sum),
		.eq  (alu_eq)
	);

	// finish step: table update, selection update, result fields
	always_comb begin
		slot_pick   = match_v_q ? match_idx_q : (free_v_q ? free_idx_q : cand_idx_q);
		n_has_sel   = has_sel_q;
		n_sel       = sel_q;
		n_sel_frame = sel_frame_q;
		n_follow    = follow_q;
		n_clean     = clean_pend_q;
		wr_en       = 1'b0;
		n_lat       = latest_q ? '0 : lat_q;
		n_lat[slot_pick] = latest_q;
		r_presented = 1'b0;
		r_written   = '0;
		r_req       = 1'b0;
		r_rtype     = REQ_PREV;
		r_anchor    = '0;
		r_redraw    = 1'b0;
		r_changed   = 1'b0;
		unique case (kind_q)
			KIND_COMMIT: begin
				wr_en     = 1'b1;
				r_written = SEL_W'(slot_pick);
				if (!has_sel_q || pres_q || (latest_q && follow_q)) begin
					r_presented = 1'b1;
					n_has_sel   = 1'b1;
					n_sel       = slot_pick;
					n_sel_frame = fid_q;
					n_follow    = latest_q;
					if (pres_q) begin
						r_redraw = clean_pend_q;
						n_clean  = 1'b0;
					end
				end
			end
			KIND_PREV, KIND_NEXT: begin
				if (sel_frame_cur == '0) begin
					// no anchor frame: ask the remote side
					r_req   = 1'b1;
					r_rtype = back ? REQ_PREV : REQ_NEXT;
				end else if (match_v_q) begin
					n_sel       = match_idx_q;
					n_sel_frame = target_q;
					n_follow    = lat_q[match_idx_q];
					r_changed   = 1'b1;
				end else if (back || !lat_q[sel_q]) begin
					r_req    = 1'b1;
					r_rtype  = back ? REQ_PREV : REQ_NEXT;
					r_anchor = sel_frame_cur;
				end
			end
			KIND_JUMP: begin
				r_req    = 1'b1;
				r_rtype  = REQ_CUR;
				r_anchor = sel_frame_cur;
				if (lat_v_q) begin
					r_changed   = !has_sel_q || (sel_q != lat_idx_q);
					n_has_sel   = 1'b1;
					n_sel       = lat_idx_q;
					n_sel_frame = lat_id_q;
					n_follow    = 1'b1;
					r_anchor    = lat_id_q;
				end
			end
			KIND_REFRESH: begin
				r_req    = 1'b1;
				r_rtype  = REQ_CUR;
				r_anchor = sel_frame_cur;
				n_clean  = clean_pend_q || clean_req_q;
			end
			default: begin
				// clear already done on acceptance; unused kinds only report
			end
		endcase
		r_index = n_has_sel ? SEL_W'(n_sel) : '0;
		r_frame = n_has_sel ? n_sel_frame : '0;
	end

	// sequencer, walk registers and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			occ_q        <= '0;
			lat_q        <= '0;
			has_sel_q    <= 1'b0;
			sel_q        <= '0;
			sel_frame_q  <= '0;
			follow_q     <= 1'b1;
			clean_pend_q <= 1'b0;
			match_v_q    <= 1'b0;
			free_v_q     <= 1'b0;
			cand_v_q     <= 1'b0;
			lat_v_q      <= 1'b0;
			newer_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					scan_q    <= '0;
					match_v_q <= 1'b0;
					free_v_q  <= 1'b0;
					cand_v_q  <= 1'b0;
					lat_v_q   <= 1'b0;
					newer_q   <= !has_sel_q || alu_sum[FRAME_W-1];
					state_q   <= needs_walk ? ST_SCAN : ST_FIN;
				end
				ST_SCAN: begin
					if (scan_occ && alu_eq && !match_v_q) begin
						match_v_q <= 1'b1;
					end
					if (!scan_occ && !free_v_q) begin
						free_v_q <= 1'b1;
					end
					if (scan_occ && scan_lat && !lat_v_q) begin
						lat_v_q <= 1'b1;
					end
					// eviction candidate: oldest or newest, never the selected slot
					if (!scan_excl && (!cand_v_q || alu_sum[FRAME_W-1])) begin
						cand_v_q <= 1'b1;
					end
					if (scan_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q      <= ST_IDLE;
						has_sel_q    <= n_has_sel;
						sel_q        <= n_sel;
						sel_frame_q  <= n_sel_frame;
						follow_q     <= n_follow;
						clean_pend_q <= n_clean;
						if (wr_en) begin
							occ_q[slot_pick] <= 1'b1;
							lat_q            <= n_lat;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (clr_now) begin
				occ_q       <= '0;
				lat_q       <= '0;
				has_sel_q   <= 1'b0;
				sel_q       <= '0;
				sel_frame_q <= '0;
				follow_q    <= 1'b1;
			end
		end
	end

	// request capture, walk payload and slot ids
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q      <= s_tuser;
			fid_q       <= s_tdata[31:0];
			latest_q    <= s_tdata[33];
			pres_q      <= s_tdata[34];
			clean_req_q <= s_tdata[35];
		end
		if (state_q == ST_PREP) begin
			target_q <= (kind_q == KIND_COMMIT) ? fid_q : alu_sum;
		end
		if (state_q == ST_SCAN) begin
			if (scan_occ && alu_eq && !match_v_q) begin
				match_idx_q <= scan_q;
			end
			if (!scan_occ && !free_v_q) begin
				free_idx_q <= scan_q;
			end
			if (scan_occ && scan_lat && !lat_v_q) begin
				lat_idx_q <= scan_q;
				lat_id_q  <= scan_id;
			end
			if (!scan_excl && (!cand_v_q || alu_sum[FRAME_W-1])) begin
				cand_idx_q <= scan_q;
				cand_id_q  <= scan_id;
			end
		end
		if (fin_go && wr_en) begin
			id_mem[slot_pick] <= fid_q;
		end
	end

	// result register, freed when the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_data_q <= {1'b0, r_changed, r_redraw, r_anchor, r_rtype, r_req,
			               r_written, r_presented, r_frame, r_index, n_has_sel};
		end
	end

	// a selection always points at an occupied slot
	assert property (@(posedge clk) disable iff (!arst_n)
		has_sel_q |-> occ_q[sel_q])
		else $error("selected slot is not occupied");

	// at most one slot carries the latest mark, and only an occupied one
	assert property (@(posedge clk) disable iff (!arst_n)
		($countones(lat_q) <= 1) && ((lat_q & ~occ_q) == '0))
		else $error("latest marks inconsistent");

	// the finish step holds while the result register is still full
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !m_tready) |=> (state_q == ST_FIN))
		else $error("finish step overran a waiting result");

	// the mirrored selected id tracks the table entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(has_sel_q && state_q == ST_IDLE) |-> (sel_frame_q == id_mem[sel_q]))
		else $error("selected frame id out of step with table");

endmodule

`default_nettype wire
